FILE: hdl/ordered_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared property wrappers for the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define OLID_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define OLID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/olid_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Shared codes, types and defaults for the ordered list cell chain.
// ----------------------------------------------------------------------------
package olid_pkg;

    // default list capacity
    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;

    // operation codes on the input tuser
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2
    } op_t;

    // status codes on the result tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  key;
    } cell_cmd_t;

    // controller states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_TRAV = 1'b1
    } fsm_t;

endpackage

FILE: hdl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and traverse
// Bounded ordered list of signed 32-bit values held in a chain of cells.
//
//   channel | dir | tdata          | tuser          | tlast
//   --------+-----+----------------+----------------+----------------------
//   s_      | in  | value [31:0]   | operation[1:0] | -
//   m_      | out | item_value     | status [1:0]   | last result of item
//
// Insert and delete update the whole chain in the transfer cycle and the
// status result is registered. A traverse emits one result per unstalled
// cycle, count results in all, by rotating the chain once round.
// The input is not ready while a traversal runs or a result waits unread.
// Reset clears the count and every cell's valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
    parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [olid_pkg::VAL_W-1:0] s_tdata,   // [31:0] value
    input  logic [1:0]                        s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [olid_pkg::VAL_W-1:0] m_tdata,   // [31:0] item_value
    output logic [1:0]                        m_tuser,   // [1:0] status
    output logic                              m_tlast
);
    import olid_pkg::*;

    `include "ordered_list_insert_delete_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    fsm_t                    state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        remain_reg, remain_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [VAL_W-1:0] m_data_reg, m_data_next;
    status_t                 m_status_reg, m_status_next;
    logic                    m_last_reg, m_last_next;

    cell_cmd_t               cmd;
    logic [DEPTH-1:0]        valid_vec;
    logic signed [VAL_W-1:0] head_value;
    logic                    found;

    logic out_free, s_acc, trav_step, is_full, is_empty;
    op_t  op;

    assign op        = op_t'(s_tuser);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == FSM_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;
    assign trav_step = (state_reg == FSM_TRAV) && out_free;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // cell chain
    olid_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .valid_vec  (valid_vec),
        .head_value (head_value),
        .found      (found)
    );

    // next state, count and traversal counter
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_acc) begin
                    case (op)
                        OP_INSERT: begin
                            if (!is_full) count_next = count_reg + CNT_W'(1);
                        end
                        OP_DELETE: begin
                            if (!is_empty && found) count_next = count_reg - CNT_W'(1);
                        end
                        OP_TRAVERSE: begin
                            if (!is_empty) begin
                                state_next  = FSM_TRAV;
                                remain_next = count_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FSM_TRAV: begin
                if (trav_step) begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // chain command and result register load
    always_comb begin
        cmd.op        = CELL_HOLD;
        cmd.key       = s_tdata;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        if (s_acc) begin
            case (op)
                OP_INSERT: begin
                    m_valid_next  = 1'b1;
                    m_data_next   = '0;
                    m_last_next   = 1'b1;
                    m_status_next = is_full ? STAT_FULL : STAT_OK;
                    if (!is_full) cmd.op = CELL_INSERT;
                end
                OP_DELETE: begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_last_next  = 1'b1;
                    if (is_empty) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        cmd.op        = CELL_DELETE;
                        m_status_next = found ? STAT_OK : STAT_NOT_FOUND;
                    end
                end
                OP_TRAVERSE: begin
                    if (is_empty) begin
                        m_valid_next  = 1'b1;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                        m_status_next = STAT_EMPTY;
                    end
                end
                default: begin
                end
            endcase
        end else if (trav_step) begin
            // emit the head and rotate it round to the tail
            cmd.op        = CELL_ROTATE;
            m_valid_next  = 1'b1;
            m_data_next   = head_value;
            m_status_next = STAT_OK;
            m_last_next   = (remain_reg == CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `OLID_ASSERT_NOW(a_count_match, aclk, aresetn, 1'b1, $countones(valid_vec) == int'(count_reg), "valid flags disagree with count")
    `OLID_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1, (valid_vec & (valid_vec + DEPTH'(1))) == '0, "valid cells not contiguous from head")
    `OLID_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, int'(count_reg) <= DEPTH, "count beyond capacity")
    `OLID_ASSERT_NEXT(a_trav_end, aclk, aresetn, trav_step && (remain_reg == CNT_W'(1)), (state_reg == FSM_IDLE) && m_tvalid && m_tlast, "traversal did not end on last")

endmodule

FILE: hdl/olid_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// One list slot: holds a value and a valid flag, takes from its right
// neighbour on a delete or rotate, and passes the first-match flag on.
// ----------------------------------------------------------------------------
module olid_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  olid_pkg::cell_cmd_t               cmd,
    input  logic signed [olid_pkg::VAL_W-1:0] head_value,
    input  logic                              left_valid,
    input  logic                              left_hit,
    input  logic                              right_valid,
    input  logic signed [olid_pkg::VAL_W-1:0] right_value,
    output logic                              valid,
    output logic signed [olid_pkg::VAL_W-1:0] value,
    output logic                              hit
);
    import olid_pkg::*;

    logic                    valid_reg, valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    match;

    // first match so far, counted from the head
    assign match = valid_reg && (value_reg == cmd.key);
    assign hit   = left_hit || match;

    // slot update
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (!valid_reg && left_valid) begin
                    valid_next = 1'b1;
                    value_next = cmd.key;
                end
            end
            CELL_DELETE: begin
                if (hit) begin
                    valid_next = right_valid;
                    value_next = right_value;
                end
            end
            CELL_ROTATE: begin
                // tail slot takes the head, the rest shift towards the head
                if (valid_reg) begin
                    value_next = right_valid ? right_value : head_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

FILE: hdl/olid_chain.sv
// ----------------------------------------------------------------------------
// Ordered list cell chain
// A row of DEPTH cells, head at cell 0, wired to their neighbours.
// ----------------------------------------------------------------------------
module olid_chain #(
    parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  olid_pkg::cell_cmd_t               cmd,
    output logic [DEPTH-1:0]                  valid_vec,
    output logic signed [olid_pkg::VAL_W-1:0] head_value,
    output logic                              found
);
    import olid_pkg::*;

    // valid flags with a fixed head guard (1) and tail guard (0)
    logic [DEPTH+1:0]        vld_ext;
    logic [DEPTH:0]          hit_w;
    logic signed [VAL_W-1:0] val_w [DEPTH+1];

    assign vld_ext[0]       = 1'b1;
    assign vld_ext[DEPTH+1] = 1'b0;
    assign hit_w[0]         = 1'b0;
    assign val_w[DEPTH]     = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        olid_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .head_value  (val_w[0]),
            .left_valid  (vld_ext[i]),
            .left_hit    (hit_w[i]),
            .right_valid (vld_ext[i+2]),
            .right_value (val_w[i+1]),
            .valid       (vld_ext[i+1]),
            .value       (val_w[i]),
            .hit         (hit_w[i+1])
        );
    end

    assign valid_vec  = vld_ext[DEPTH:1];
    assign head_value = val_w[0];
    assign found      = hit_w[DEPTH];

endmodule

FILE: bench/olid_list_checker.sv
// ----------------------------------------------------------------------------
// Ordered list result checker
// Watches both stream channels of the ordered list block, keeps its own copy
// of the list, works out the results due for every accepted command and
// compares each accepted result transfer with the oldest one still due.
// ----------------------------------------------------------------------------
module olid_list_checker #(
    parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic signed [olid_pkg::VAL_W-1:0] s_tdata,   // [31:0] value
    input  logic [1:0]                        s_tuser,   // [1:0] operation
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic signed [olid_pkg::VAL_W-1:0] m_tdata,   // [31:0] item_value
    input  logic [1:0]                        m_tuser,   // [1:0] status
    input  logic                              m_tlast,
    output int                                n_errors,
    output int                                n_pending,
    output int                                n_checked,
    output int                                n_full,
    output int                                n_empty,
    output int                                n_missing
);
    import olid_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  item;
        logic              last;
    } list_result_t;

    // shadow of the list, head at index 0
    logic [VAL_W-1:0] list_vals [DEPTH];
    int               list_len;
    list_result_t     due_results [$];

    // apply one command to the shadow list and queue the results it causes
    task automatic apply_list_op(input logic [1:0] op, input logic [VAL_W-1:0] v);
        int hit;
        int i;
        hit = -1;
        case (op)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    due_results.push_back('{STAT_FULL, '0, 1'b1});
                end else begin
                    list_vals[list_len] = v;
                    list_len++;
                    due_results.push_back('{STAT_OK, '0, 1'b1});
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    due_results.push_back('{STAT_EMPTY, '0, 1'b1});
                end else begin
                    for (i = 0; i < list_len; i++)
                        if (hit < 0 && list_vals[i] == v) hit = i;
                    if (hit < 0) begin
                        due_results.push_back('{STAT_NOT_FOUND, '0, 1'b1});
                    end else begin
                        // close the gap so order is kept
                        for (i = hit; i < list_len - 1; i++)
                            list_vals[i] = list_vals[i + 1];
                        list_len--;
                        due_results.push_back('{STAT_OK, '0, 1'b1});
                    end
                end
            end
            OP_TRAVERSE: begin
                if (list_len == 0) begin
                    due_results.push_back('{STAT_EMPTY, '0, 1'b1});
                end else begin
                    for (i = 0; i < list_len; i++)
                        due_results.push_back('{STAT_OK, list_vals[i], (i == list_len - 1)});
                end
            end
            default: ;  // unused code: no state change, no result
        endcase
    endtask

    // result side first, then the command side; results are registered so a
    // command accepted at this edge cannot have a result at the same edge
    always @(posedge aclk) begin
        list_result_t want;
        logic         bad;
        if (!aresetn) begin
            list_len = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result transfer: expected none, got status %0d value %h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = due_results.pop_front();
                    bad  = 1'b0;
                    n_checked++;
                    case (want.status)
                        STAT_FULL:      n_full++;
                        STAT_EMPTY:     n_empty++;
                        STAT_NOT_FOUND: n_missing++;
                        default: ;
                    endcase
                    if (m_tuser !== want.status) begin
                        bad = 1'b1;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                    end
                    if (m_tdata !== want.item) begin
                        bad = 1'b1;
                        $display("%0t: item_value mismatch: expected %h, got %h",
                                 $time, want.item, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        bad = 1'b1;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                    if (bad) n_errors++;
                end
            end
            if (s_tvalid && s_tready)
                apply_list_op(s_tuser, s_tdata);
        end
        n_pending <= due_results.size();
    end

endmodule

FILE: bench/tb_ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Ordered list testbench
// Drives insert, delete and traverse commands into the ordered list block in
// random bursts, stalls the result side on a pattern of its own, and leaves
// all prediction and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    localparam int         DEPTH     = DEPTH_DEF;
    localparam int         N_RANDOM  = 135;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic signed [VAL_W-1:0]  s_tdata  = '0;   // [31:0] value
    logic [1:0]               s_tuser  = '0;   // [1:0] operation
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic signed [VAL_W-1:0]  m_tdata;         // [31:0] item_value
    logic [1:0]               m_tuser;         // [1:0] status
    logic                     m_tlast;

    int n_errors, n_pending, n_checked, n_full, n_empty, n_missing;
    int n_sent;
    int burst_left;
    int stall_mode, stall_run;

    // pool of recently inserted values, so most deletes find a match
    logic [VAL_W-1:0] recent_vals [$];

    ordered_list_insert_delete #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    olid_list_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_checked (n_checked),
        .n_full    (n_full),
        .n_empty   (n_empty),
        .n_missing (n_missing)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("tb_ordered_list_insert_delete: errors");
        $finish;
    end

    // result side stalls: the mode changes at the end of each randomly long run
    always @(posedge aclk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(20, 80);
        end else begin
            stall_run  <= stall_run - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_run % 3 != 0);
        endcase
    end

    // bursts of random length with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // one command transfer; returns at the edge where it was accepted
    task automatic send_cmd(input logic [1:0] op, input logic [VAL_W-1:0] v);
        pace();
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        if (op == OP_INSERT) begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 24) void'(recent_vals.pop_front());
        end
    endtask

    // hold off until every result due has been taken
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    initial begin
        logic [1:0]       op;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] tail_val;
        int               k;
        int               pick;
        bit               grow;

        grow = 1'b1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, extremes, duplicates, full list
        send_cmd(OP_TRAVERSE, '0);
        send_cmd(OP_DELETE, '0);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_INSERT, 32'h7fff_ffff);
        send_cmd(OP_INSERT, '0);
        send_cmd(OP_INSERT, '1);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_TRAVERSE, '0);
        send_cmd(OP_DELETE, 32'h8000_0000);     // first of two equal entries
        send_cmd(OP_DELETE, 32'd12345);         // no match
        send_cmd(OP_UNUSED, $urandom());        // ignored code
        tail_val = '0;
        repeat (DEPTH - 4) begin
            tail_val = $urandom();
            send_cmd(OP_INSERT, tail_val);
        end
        send_cmd(OP_INSERT, $urandom());        // insert into a full list
        send_cmd(OP_TRAVERSE, '0);
        send_cmd(OP_DELETE, tail_val);          // delete at the tail
        send_cmd(OP_DELETE, '0);                // delete from the middle
        drain();

        // random: alternate phases that lean towards filling or emptying
        k = 0;
        while (k < N_RANDOM) begin
            if ($urandom_range(0, 19) == 0) grow = ~grow;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = OP_UNUSED;
            else if (pick < 18)
                op = OP_TRAVERSE;
            else if (pick < (grow ? 73 : 43))
                op = OP_INSERT;
            else
                op = OP_DELETE;

            pick = $urandom_range(0, 9);
            if (op == OP_DELETE && recent_vals.size() != 0 && pick < 7)
                v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
            else if (pick == 8)
                v = corner_value();
            else if (pick == 9)
                v = $urandom_range(0, 7);       // small values give duplicates
            else
                v = $urandom();

            send_cmd(op, v);
            if (op != OP_UNUSED) k++;
            if ($urandom_range(0, 29) == 0) drain();
        end

        drain();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d command transfers and %0d checked result transfers;",
                 n_sent, n_checked);
        $display("full %0d, empty %0d, not found %0d.", n_full, n_empty, n_missing);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_ordered_list_insert_delete: clean");
        end else begin
            $display("tb_ordered_list_insert_delete: errors");
        end
        $finish;
    end

endmodule
